/* rtl/elgamal_modexp_engine_core_assert.svh */
// Assertion macros used by the checker file of the engine.
`ifndef ELGAMAL_MODEXP_ENGINE_CORE_ASSERT_SVH
`define ELGAMAL_MODEXP_ENGINE_CORE_ASSERT_SVH

// Implication in the same cycle, checked outside reset.
`define EMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle, checked outside reset.
`define EMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/emc_pkg.sv */
`default_nettype none
package emc_pkg;

  // Width of every data field of operands and results.
  localparam int FIELD_W = 31;
  // Default width of the modulus register.
  localparam int MOD_BITS_DEF = 31;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP  = 2'd2;

  // Operation selectors.
  localparam logic [1:0] FUNC_PUBKEY  = 2'd0;
  localparam logic [1:0] FUNC_ENCRYPT = 2'd1;
  localparam logic [1:0] FUNC_DECRYPT = 2'd2;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  // Reset value of the generator register.
  localparam logic [FIELD_W-1:0] GENERATOR_RST = 31'd7;

  typedef struct packed {
    logic [1:0]         func;
    logic [FIELD_W-1:0] random_key;
    logic [FIELD_W-1:0] message;
    logic [FIELD_W-1:0] cipher_first;
    logic [FIELD_W-1:0] cipher_second;
  } emc_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_first;
    logic [FIELD_W-1:0] result_second;
    logic               status;
  } emc_out_t;

endpackage
`default_nettype wire

/* rtl/elgamal_modexp_engine_core.sv */
// Every modular product runs on the shared unit after its launch; the set exponent bits set
// how many products an item takes.
// Throughput: one item at a time; busy stays high until the cycle of the done strobe ends.
// Reset (rst, synchronous) returns the sequencer to idle and loads the configuration register defaults.
// The receiver cannot stall: the result is on the ports while done is high and holds until the next start.
`default_nettype none
module elgamal_modexp_engine_core #(
  parameter int MOD_BITS = emc_pkg::MOD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire emc_pkg::emc_in_t              operands,
  output logic                               done,
  output emc_pkg::emc_out_t                  result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [emc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [emc_pkg::FIELD_W-1:0]   cfg_data
);
  import emc_pkg::*;

  localparam int W = MOD_BITS;
  localparam int CNT_W = $clog2(FIELD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FIELD_W - 1);

  typedef enum logic [14:0] {
    S_IDLE      = 15'b000000000000001,
    S_POW_START = 15'b000000000000010,
    S_POW_BASE  = 15'b000000000000100,
    S_POW_LOOP  = 15'b000000000001000,
    S_POW_ACC   = 15'b000000000010000,
    S_POW_SQR   = 15'b000000000100000,
    S_POW_NEXT  = 15'b000000001000000,
    S_POW_END   = 15'b000000010000000,
    S_FMUL      = 15'b000000100000000,
    S_FIN       = 15'b000001000000000,
    S_INV_LOOP  = 15'b000010000000000,
    S_INV_Q     = 15'b000100000000000,
    S_INV_T     = 15'b001000000000000,
    S_WAIT      = 15'b010000000000000,
    S_DONE      = 15'b100000000000000
  } state_t;

  typedef enum logic [1:0] {
    JOB_Y  = 2'd0,
    JOB_GK = 2'd1,
    JOB_YK = 2'd2,
    JOB_AX = 2'd3
  } job_t;

  state_t state, ret;
  job_t   job;

  // Configuration registers.
  logic [W-1:0]       modulus;
  logic [FIELD_W-1:0] generator;
  logic [FIELD_W-1:0] priv_exp;

  // Item and working registers.
  emc_in_t            op;
  logic [W-1:0]       y, base, acc, t_reg, nt, er, enr;
  logic [FIELD_W-1:0] expo;
  logic [CNT_W-1:0]   ecnt;
  logic [FIELD_W-1:0] r0, r1;
  logic               st;

  // Shared unit registers.
  logic [W-1:0]       u_acc, u_add, u_div;
  logic [FIELD_W-1:0] u_mult;
  logic [CNT_W-1:0]   u_cnt;

  // Launch request from the sequencer.
  logic               launch;
  logic [W-1:0]       l_add, l_div;
  logic [FIELD_W-1:0] l_mult;
  state_t             l_ret;

  // One step: shift in a multiplier bit, then reduce by up to two subtracts.
  logic [W+1:0] sum, s1, s2, div_x;
  logic         qbit;

  always_comb begin
    div_x = (W+2)'(u_div);
    sum   = {1'b0, u_acc, 1'b0} + (u_mult[FIELD_W-1] ? (W+2)'(u_add) : '0);
    qbit  = (sum >= div_x);
    s1    = qbit ? sum - div_x : sum;
    s2    = (s1 >= div_x) ? s1 - div_x : s1;
  end

  // Operand selection for the unit.
  always_comb begin
    launch = 1'b0;
    l_add  = W'(1);
    l_div  = modulus;
    l_mult = '0;
    l_ret  = S_IDLE;
    unique case (state)
      S_POW_START: begin
        launch = 1'b1;
        l_ret  = S_POW_BASE;
        case (job) inside
          JOB_Y, JOB_GK: l_mult = generator;
          JOB_YK:        l_mult = FIELD_W'(y);
          default:       l_mult = op.cipher_first;
        endcase
      end
      S_POW_LOOP: begin
        launch = expo[0];
        l_add  = base;
        l_mult = FIELD_W'(acc);
        l_ret  = S_POW_ACC;
      end
      S_POW_ACC, S_POW_SQR: begin
        launch = 1'b1;
        l_add  = base;
        l_mult = FIELD_W'(base);
        l_ret  = S_POW_NEXT;
      end
      S_POW_END: begin
        launch = (job == JOB_YK);
        l_mult = op.message;
        l_ret  = S_FMUL;
      end
      S_FMUL: begin
        launch = 1'b1;
        l_add  = t_reg;
        l_mult = FIELD_W'(u_acc);
        l_ret  = S_FIN;
      end
      S_INV_LOOP: begin
        if (enr != '0) begin
          launch = 1'b1;
          l_div  = enr;
          l_mult = FIELD_W'(er);
          l_ret  = S_INV_Q;
        end else begin
          launch = (er == W'(1));
          l_mult = op.cipher_second;
          l_ret  = S_FMUL;
        end
      end
      S_INV_Q: begin
        launch = 1'b1;
        l_add  = nt;
        l_mult = u_mult;
        l_ret  = S_INV_T;
      end
      default: launch = 1'b0;
    endcase
  end

  // Sequencer, configuration and shared unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      job       <= JOB_Y;
      modulus   <= '1;
      generator <= GENERATOR_RST;
      priv_exp  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MODULUS:   modulus   <= cfg_data[W-1:0];
          CFG_GENERATOR: generator <= cfg_data;
          CFG_PRIV_EXP:  priv_exp  <= cfg_data;
          default:       ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            op <= operands;
            r0 <= '0;
            r1 <= '0;
            st <= 1'b0;
            if (modulus < W'(2)) begin
              st    <= 1'b1;
              state <= S_DONE;
            end else begin
              case (operands.func) inside
                FUNC_PUBKEY, FUNC_ENCRYPT: begin
                  job   <= JOB_Y;
                  state <= S_POW_START;
                end
                FUNC_DECRYPT: begin
                  job   <= JOB_AX;
                  state <= S_POW_START;
                end
                default: state <= S_DONE;
              endcase
            end
          end
        end
        S_POW_START: ;
        S_POW_BASE: begin
          base  <= u_acc;
          acc   <= W'(1);
          ecnt  <= '0;
          expo  <= (job == JOB_Y || job == JOB_AX) ? priv_exp : op.random_key;
          state <= S_POW_LOOP;
        end
        S_POW_LOOP: begin
          if (!expo[0]) state <= S_POW_SQR;
        end
        S_POW_ACC: acc <= u_acc;
        S_POW_SQR: ;
        S_POW_NEXT: begin
          base <= u_acc;
          expo <= expo >> 1;
          ecnt <= ecnt + CNT_W'(1);
          state <= (ecnt == LAST_STEP) ? S_POW_END : S_POW_LOOP;
        end
        S_POW_END: begin
          case (job)
            JOB_Y: begin
              y <= acc;
              if (op.func == FUNC_PUBKEY) begin
                r0    <= FIELD_W'(acc);
                state <= S_DONE;
              end else begin
                job   <= JOB_GK;
                state <= S_POW_START;
              end
            end
            JOB_GK: begin
              r0    <= FIELD_W'(acc);
              job   <= JOB_YK;
              state <= S_POW_START;
            end
            JOB_YK: t_reg <= acc;
            default: begin
              er    <= modulus;
              enr   <= acc;
              t_reg <= '0;
              nt    <= W'(1);
              state <= S_INV_LOOP;
            end
          endcase
        end
        S_FMUL: ;
        S_FIN: begin
          if (op.func == FUNC_ENCRYPT) r1 <= FIELD_W'(u_acc);
          else r0 <= FIELD_W'(u_acc);
          state <= S_DONE;
        end
        S_INV_LOOP: begin
          // No inverse when the final remainder is not one.
          if (enr == '0 && er != W'(1)) begin
            st    <= 1'b1;
            state <= S_DONE;
          end
        end
        S_INV_Q: begin
          er  <= enr;
          enr <= u_acc;
        end
        S_INV_T: begin
          // Cofactor kept reduced modulo p.
          t_reg <= nt;
          nt    <= (t_reg >= u_acc) ? t_reg - u_acc : t_reg - u_acc + modulus;
          state <= S_INV_LOOP;
        end
        S_WAIT: begin
          u_acc  <= s2[W-1:0];
          u_mult <= {u_mult[FIELD_W-2:0], qbit};
          u_cnt  <= u_cnt + CNT_W'(1);
          if (u_cnt == LAST_STEP) state <= ret;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase

      if (launch) begin
        u_acc  <= '0;
        u_add  <= l_add;
        u_div  <= l_div;
        u_mult <= l_mult;
        u_cnt  <= '0;
        ret    <= l_ret;
        state  <= S_WAIT;
      end
    end
  end

  // Port drive.
  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign cfg_ready = 1'b1;
  assign result.result_first  = r0;
  assign result.result_second = r1;
  assign result.status        = st;

endmodule
`default_nettype wire

/* rtl/emc_checker.sv */
`default_nettype none
`include "elgamal_modexp_engine_core_assert.svh"
module emc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire emc_pkg::emc_out_t result
);
  import emc_pkg::*;

  // A result only appears while an item is in flight.
  `EMC_ASSERT_NOW(a_done_busy, clk, rst, done, busy, "done without busy")
  // An accepted item makes the engine busy.
  `EMC_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "item not taken")
  // The engine frees up right after the result.
  `EMC_ASSERT_NEXT(a_done_free, clk, rst, done, !busy && !done, "not idle after done")
  // A set status (failed inverse or modulus below two) gives a zero result.
  `EMC_ASSERT_NOW(a_status_zero, clk, rst, done && result.status,
    result.result_first == '0 && result.result_second == '0, "status with nonzero result")

endmodule

bind elgamal_modexp_engine_core emc_checker u_emc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire
